// ----- hdl/c8ic_pkg.sv -----
// Shared types, constants and tables for the CHIP-8 instruction core.
// Used by the sequencer, datapath and top level; depends on nothing.
`timescale 1ns / 1ps
package c8ic_pkg;

	// Machine geometry.
	localparam int SCREEN_WIDTH  = 64;
	localparam int SCREEN_HEIGHT = 32;
	localparam int STACK_DEPTH   = 16;
	localparam int MEMORY_BYTES  = 4096;
	localparam int GLYPH_BYTES   = 80;

	localparam int ADDR_W  = $clog2(MEMORY_BYTES);
	localparam int STK_AW  = $clog2(STACK_DEPTH);
	localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
	localparam int ROW_AW  = $clog2(SCREEN_HEIGHT);
	localparam int COL_W   = $clog2(SCREEN_WIDTH);

	// Configuration registers.
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FONT_BASE     = 1'b1;
	localparam logic [ADDR_W-1:0] START_RESET = 12'h200;
	localparam logic [ADDR_W-1:0] FONT_RESET  = 12'h000;

	// Input actions.
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_EXEC  = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;
	localparam logic [1:0] ACT_PIXEL = 2'd3;

	// Opcode groups (top nibble).
	localparam logic [3:0] NIB_SYS  = 4'h0;
	localparam logic [3:0] NIB_JP   = 4'h1;
	localparam logic [3:0] NIB_CALL = 4'h2;
	localparam logic [3:0] NIB_SEI  = 4'h3;
	localparam logic [3:0] NIB_SNEI = 4'h4;
	localparam logic [3:0] NIB_SER  = 4'h5;
	localparam logic [3:0] NIB_LDI  = 4'h6;
	localparam logic [3:0] NIB_ADDI = 4'h7;
	localparam logic [3:0] NIB_ALU  = 4'h8;
	localparam logic [3:0] NIB_SNER = 4'h9;
	localparam logic [3:0] NIB_LDIX = 4'hA;
	localparam logic [3:0] NIB_JPV0 = 4'hB;
	localparam logic [3:0] NIB_RND  = 4'hC;
	localparam logic [3:0] NIB_DRW  = 4'hD;
	localparam logic [3:0] NIB_KEY  = 4'hE;
	localparam logic [3:0] NIB_MISC = 4'hF;

	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;

	// Register-to-register operations (low nibble of 8XYN).
	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_RSB = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	// Key tests and miscellaneous FXNN operations.
	localparam logic [7:0] KEY_DOWN = 8'h9E;
	localparam logic [7:0] KEY_UP   = 8'hA1;
	localparam logic [7:0] FN_GETDT = 8'h07;
	localparam logic [7:0] FN_WAITK = 8'h0A;
	localparam logic [7:0] FN_SETDT = 8'h15;
	localparam logic [7:0] FN_SETST = 8'h18;
	localparam logic [7:0] FN_ADDI  = 8'h1E;
	localparam logic [7:0] FN_FONT  = 8'h29;
	localparam logic [7:0] FN_BCD   = 8'h33;
	localparam logic [7:0] FN_STORE = 8'h55;
	localparam logic [7:0] FN_LOAD  = 8'h65;

	localparam logic [3:0] FLAG_REG = 4'hF;

	// Datapath commands issued by the sequencer.
	typedef enum logic [4:0] {
		CMD_NONE, CMD_INIT, CMD_FONT, CMD_MEMWR, CMD_TICK, CMD_PIXRD, CMD_PIXCAP,
		CMD_FHI, CMD_FLO, CMD_RX, CMD_RY, CMD_DEC, CMD_EXEC, CMD_WB, CMD_RET,
		CMD_CLS, CMD_BCD, CMD_STRD, CMD_STWR, CMD_LDRD, CMD_LDWR, CMD_DRD,
		CMD_DWR, CMD_DVF, CMD_FINISH
	} cmd_code_t;

	typedef struct packed {
		cmd_code_t code;
		logic      take;
	} ctl_cmd_t;

	typedef struct packed {
		logic [15:0]       opcode;
		logic [ADDR_W-1:0] cnt;
		logic              ret_ok;
		logic              out_free;
	} ctl_sts_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [ADDR_W-1:0] mem_address;
		logic [7:0]        mem_byte;
		logic [15:0]       pressed_keys;
		logic [7:0]        random_byte;
		logic [COL_W-1:0]  pixel_x;
		logic [ROW_AW-1:0] pixel_y;
	} item_t;

	localparam logic [7:0] GLYPH_ROM [GLYPH_BYTES] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	// Glyph byte k of the built-in hex font; zero past the end.
	function automatic logic [7:0] glyph_byte(input logic [6:0] k);
		logic [7:0] b;
		b = 8'h00;
		if (k < 7'(GLYPH_BYTES)) b = GLYPH_ROM[k];
		return b;
	endfunction

endpackage

// ----- hdl/c8ic_if.sv -----
// Handshake channels of the CHIP-8 instruction core: input items and results.
// Stands alone; its field widths match those of c8ic_pkg.
`timescale 1ns / 1ps
interface c8ic_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [11:0] mem_address;
	logic [7:0]  mem_byte;
	logic [15:0] pressed_keys;
	logic [7:0]  random_byte;
	logic [5:0]  pixel_x;
	logic [4:0]  pixel_y;

	modport source (output valid, action, mem_address, mem_byte, pressed_keys,
		random_byte, pixel_x, pixel_y, input ready);
	modport sink (input valid, action, mem_address, mem_byte, pressed_keys,
		random_byte, pixel_x, pixel_y, output ready);
endinterface

interface c8ic_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] program_counter;
	logic [15:0] executed_opcode;
	logic        pixel_value;
	logic        screen_changed;
	logic        key_wait;
	logic        sound_on;
	logic        stack_fault;

	modport source (output valid, program_counter, executed_opcode, pixel_value,
		screen_changed, key_wait, sound_on, stack_fault, input ready);
	modport sink (input valid, program_counter, executed_opcode, pixel_value,
		screen_changed, key_wait, sound_on, stack_fault, output ready);
endinterface

// ----- hdl/c8ic_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for program memory, registers, stack and frame.
`timescale 1ns / 1ps
module c8ic_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/c8ic_ctrl.sv -----
// Sequencer of the CHIP-8 instruction core: walks each action through its steps.
// Depends on c8ic_pkg; drives the datapath through ctl_cmd_t and reads ctl_sts_t.
`timescale 1ns / 1ps
module c8ic_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [1:0]                     in_action,
	output logic                           in_ready,
	input  logic                           cfg_write,
	input  logic [c8ic_pkg::CFG_IDX_W-1:0] cfg_index,
	input  c8ic_pkg::ctl_sts_t             sts,
	output c8ic_pkg::ctl_cmd_t             cmd
);
	import c8ic_pkg::*;

	typedef enum logic [24:0] {
		S_INIT   = 25'h0000001, S_FONT  = 25'h0000002, S_IDLE  = 25'h0000004,
		S_MEMWR  = 25'h0000008, S_TICK  = 25'h0000010, S_PIXRD = 25'h0000020,
		S_PIXCAP = 25'h0000040, S_FHI   = 25'h0000080, S_FLO   = 25'h0000100,
		S_RX     = 25'h0000200, S_RY    = 25'h0000400, S_DEC   = 25'h0000800,
		S_EXEC   = 25'h0001000, S_WB    = 25'h0002000, S_RET   = 25'h0004000,
		S_CLS    = 25'h0008000, S_BCD   = 25'h0010000, S_STRD  = 25'h0020000,
		S_STWR   = 25'h0040000, S_LDRD  = 25'h0080000, S_LDWR  = 25'h0100000,
		S_DRD    = 25'h0200000, S_DWR   = 25'h0400000, S_DVF   = 25'h0800000,
		S_FIN    = 25'h1000000
	} state_t;

	state_t state_q, state_d;
	logic   font_wr;
	logic [3:0] nib, xi, ni;
	logic [7:0] nn;
	logic [4:0] cnt_next;

	assign nib = sts.opcode[15:12];
	assign xi  = sts.opcode[11:8];
	assign ni  = sts.opcode[3:0];
	assign nn  = sts.opcode[7:0];
	assign cnt_next = sts.cnt[4:0] + 5'd1;
	assign font_wr = cfg_write && (cfg_index == CFG_FONT_BASE);
	assign in_ready = (state_q == S_IDLE) && !font_wr;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: if (sts.cnt == ADDR_W'(MEMORY_BYTES - 1)) state_d = S_FONT;
			S_FONT: if (sts.cnt == ADDR_W'(GLYPH_BYTES - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (font_wr) state_d = S_FONT;
				else if (in_valid) begin
					case (in_action)
						ACT_WRITE: state_d = S_MEMWR;
						ACT_EXEC:  state_d = S_FHI;
						ACT_TICK:  state_d = S_TICK;
						default:   state_d = S_PIXRD;
					endcase
				end
			end
			S_MEMWR:  state_d = S_FIN;
			S_TICK:   state_d = S_FIN;
			S_PIXRD:  state_d = S_PIXCAP;
			S_PIXCAP: state_d = S_FIN;
			S_FHI:    state_d = S_FLO;
			S_FLO:    state_d = S_RX;
			S_RX:     state_d = S_RY;
			S_RY:     state_d = S_DEC;
			S_DEC:    state_d = S_EXEC;
			S_EXEC: begin
				state_d = S_FIN;
				case (nib)
					NIB_SYS: begin
						if (sts.opcode == OP_CLS) state_d = S_CLS;
						else if (sts.opcode == OP_RET && sts.ret_ok) state_d = S_RET;
					end
					NIB_ALU: begin
						if (ni == ALU_ADD || ni == ALU_SUB || ni == ALU_SHR ||
						    ni == ALU_RSB || ni == ALU_SHL) state_d = S_WB;
					end
					NIB_DRW: state_d = (ni == 4'h0) ? S_DVF : S_DRD;
					NIB_MISC: begin
						if (nn == FN_BCD) state_d = S_BCD;
						else if (nn == FN_STORE) state_d = S_STRD;
						else if (nn == FN_LOAD) state_d = S_LDRD;
					end
					default: state_d = S_FIN;
				endcase
			end
			S_WB:   state_d = S_FIN;
			S_RET:  state_d = S_FIN;
			S_CLS:  if (sts.cnt == ADDR_W'(SCREEN_HEIGHT - 1)) state_d = S_FIN;
			S_BCD:  if (sts.cnt == ADDR_W'(2)) state_d = S_FIN;
			S_STRD: state_d = S_STWR;
			S_STWR: state_d = (sts.cnt[3:0] == xi) ? S_FIN : S_STRD;
			S_LDRD: state_d = S_LDWR;
			S_LDWR: state_d = (sts.cnt[3:0] == xi) ? S_FIN : S_LDRD;
			S_DRD:  state_d = S_DWR;
			S_DWR:  state_d = (cnt_next == {1'b0, ni}) ? S_DVF : S_DRD;
			S_DVF:  state_d = S_FIN;
			S_FIN:  if (sts.out_free) state_d = S_IDLE;
			default: state_d = S_INIT;
		endcase
	end

	// Command for the datapath in each state.
	always_comb begin
		cmd.take = (state_q == S_IDLE) && in_valid && !font_wr;
		case (state_q)
			S_INIT:   cmd.code = CMD_INIT;
			S_FONT:   cmd.code = CMD_FONT;
			S_MEMWR:  cmd.code = CMD_MEMWR;
			S_TICK:   cmd.code = CMD_TICK;
			S_PIXRD:  cmd.code = CMD_PIXRD;
			S_PIXCAP: cmd.code = CMD_PIXCAP;
			S_FHI:    cmd.code = CMD_FHI;
			S_FLO:    cmd.code = CMD_FLO;
			S_RX:     cmd.code = CMD_RX;
			S_RY:     cmd.code = CMD_RY;
			S_DEC:    cmd.code = CMD_DEC;
			S_EXEC:   cmd.code = CMD_EXEC;
			S_WB:     cmd.code = CMD_WB;
			S_RET:    cmd.code = CMD_RET;
			S_CLS:    cmd.code = CMD_CLS;
			S_BCD:    cmd.code = CMD_BCD;
			S_STRD:   cmd.code = CMD_STRD;
			S_STWR:   cmd.code = CMD_STWR;
			S_LDRD:   cmd.code = CMD_LDRD;
			S_LDWR:   cmd.code = CMD_LDWR;
			S_DRD:    cmd.code = CMD_DRD;
			S_DWR:    cmd.code = CMD_DWR;
			S_DVF:    cmd.code = CMD_DVF;
			S_FIN:    cmd.code = CMD_FINISH;
			default:  cmd.code = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_INIT;
		else state_q <= state_d;
	end

	// A transaction is taken only from the idle state.
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> (state_q == S_MEMWR || state_q == S_FHI ||
		              state_q == S_TICK || state_q == S_PIXRD))
		else $error("item taken outside the idle state");
	// Every instruction passes through decode before execution.
	a_exec_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> $past(state_q == S_DEC))
		else $error("execute without decode");
	// The sprite loop alternates read and write.
	a_draw_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DWR) |-> $past(state_q == S_DRD))
		else $error("sprite write without row read");
endmodule

// ----- hdl/c8ic_dp.sv -----
// Datapath of the CHIP-8 instruction core: machine state, memories, result register.
// Depends on c8ic_pkg, c8ic_ram and c8ic_out_if; commanded by c8ic_ctrl.
`timescale 1ns / 1ps
module c8ic_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  c8ic_pkg::item_t                 itm,
	input  logic                            cfg_write,
	input  logic [c8ic_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [c8ic_pkg::CFG_DATA_W-1:0] cfg_data,
	input  c8ic_pkg::ctl_cmd_t              cmd,
	output c8ic_pkg::ctl_sts_t              sts,
	c8ic_out_if.source                      result
);
	import c8ic_pkg::*;

	// Architectural state.
	logic [ADDR_W-1:0]  font_q, pc_q, i_q, cnt_q;
	logic [LEVEL_W-1:0] lvl_q;
	logic [7:0]         dt_q, st_q;
	logic [15:0]        vvalid_q;
	logic               vval_rd_q;

	// Current item and instruction.
	item_t       itm_q;
	logic [7:0]  hi_q, vx_q, vy_q, wb_q;
	logic [15:0] op_q;
	logic        hit_q, flip_q, row_ok_q;
	logic [ROW_AW-1:0] row_q;

	// Per-item result bits and the output register.
	logic [15:0] word_q;
	logic        pix_q, chg_q, wait_q, fault_q;
	logic        ovalid_q;
	logic [ADDR_W-1:0] opc_q;
	logic [15:0] oword_q;
	logic        opix_q, ochg_q, owait_q, osnd_q, ofault_q;

	// Memory ports.
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa, mem_ra;
	logic [7:0]        mem_wd, mem_rd;
	logic              v_we;
	logic [3:0]        v_wa, v_ra;
	logic [7:0]        v_wd, v_rd, vrd;
	logic              stk_we;
	logic [STK_AW-1:0] stk_wa, stk_ra;
	logic [ADDR_W-1:0] stk_wd, stk_rd;
	logic              fr_we;
	logic [ROW_AW-1:0] fr_wa, fr_ra;
	logic [SCREEN_WIDTH-1:0] fr_wd, fr_rd;

	c8ic_ram #(.W(8), .D(MEMORY_BYTES)) u_mem (.clk(clk), .we(mem_we), .waddr(mem_wa),
		.wdata(mem_wd), .raddr(mem_ra), .rdata(mem_rd));
	c8ic_ram #(.W(8), .D(16)) u_vreg (.clk(clk), .we(v_we), .waddr(v_wa),
		.wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
	c8ic_ram #(.W(ADDR_W), .D(STACK_DEPTH)) u_stack (.clk(clk), .we(stk_we),
		.waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd));
	c8ic_ram #(.W(SCREEN_WIDTH), .D(SCREEN_HEIGHT)) u_frame (.clk(clk), .we(fr_we),
		.waddr(fr_wa), .wdata(fr_wd), .raddr(fr_ra), .rdata(fr_rd));

	// Unwritten registers read as zero.
	assign vrd = vval_rd_q ? v_rd : 8'h00;

	// Instruction fields.
	logic [3:0]        nib, xi, yi, ni;
	logic [7:0]        nn;
	logic [ADDR_W-1:0] nnn, pc2, pc4, pc1;
	logic [LEVEL_W-1:0] lvl_m1;
	assign nib = op_q[15:12];
	assign xi  = op_q[11:8];
	assign yi  = op_q[7:4];
	assign ni  = op_q[3:0];
	assign nn  = op_q[7:0];
	assign nnn = op_q[11:0];
	assign pc1 = pc_q + ADDR_W'(1);
	assign pc2 = pc_q + ADDR_W'(2);
	assign pc4 = pc_q + ADDR_W'(4);
	assign lvl_m1 = lvl_q - LEVEL_W'(1);

	// Highest pressed key.
	logic [3:0] kidx;
	logic       kfound;
	always_comb begin
		kidx = 4'h0;
		kfound = 1'b0;
		for (int k = 0; k < 16; k++) begin
			if (itm_q.pressed_keys[k]) begin
				kidx = 4'(k);
				kfound = 1'b1;
			end
		end
	end

	logic kdown;
	assign kdown = (vx_q[7:4] == 4'h0) && itm_q.pressed_keys[vx_q[3:0]];

	// Decimal digits of Vx by compares against constant thresholds.
	logic [1:0] bcd_h;
	logic [6:0] bcd_r;
	logic [3:0] bcd_t, bcd_o;
	logic [7:0] bcd_byte;
	always_comb begin
		bcd_h = (vx_q >= 8'd200) ? 2'd2 : (vx_q >= 8'd100) ? 2'd1 : 2'd0;
		case (bcd_h)
			2'd2:    bcd_r = 7'(vx_q - 8'd200);
			2'd1:    bcd_r = 7'(vx_q - 8'd100);
			default: bcd_r = vx_q[6:0];
		endcase
		bcd_t = 4'h0;
		for (int k = 1; k < 10; k++) begin
			if (bcd_r >= 7'(k * 10)) bcd_t = 4'(k);
		end
		bcd_o = 4'(bcd_r - 7'({3'b000, bcd_t} * 7'd10));
		case (cnt_q[1:0])
			2'd0:    bcd_byte = {6'b0, bcd_h};
			2'd1:    bcd_byte = {4'b0, bcd_t};
			default: bcd_byte = {4'b0, bcd_o};
		endcase
	end

	// Sprite row placement with clipping at the screen edges.
	logic [9:0] py_s;
	logic       py_ok;
	logic [SCREEN_WIDTH-1:0] smask;
	assign py_s  = {{2{vy_q[7]}}, vy_q} + {5'b0, cnt_q[4:0]};
	assign py_ok = (py_s[9:ROW_AW] == '0);
	always_comb begin
		logic [9:0] pxs;
		smask = '0;
		for (int c = 0; c < 8; c++) begin
			pxs = {{2{vx_q[7]}}, vx_q} + 10'(c);
			if (pxs[9:COL_W] == '0 && mem_rd[7-c]) smask[pxs[COL_W-1:0]] = 1'b1;
		end
	end

	// Instruction effects, computed combinationally for the execute step.
	logic [ADDR_W-1:0] ex_pc, ex_i;
	logic ex_vwe, ex_iwe, ex_push, ex_pop, ex_fault, ex_wait, ex_chg, ex_dtwe, ex_stwe;
	logic [3:0] ex_va;
	logic [7:0] ex_vd, ex_wb;
	logic [8:0] sum8;
	logic [ADDR_W:0] sum_i;
	assign sum8  = {1'b0, vx_q} + {1'b0, vy_q};
	assign sum_i = {1'b0, i_q} + {5'b0, vx_q};

	always_comb begin
		ex_pc = pc2; ex_i = i_q; ex_va = xi; ex_vd = 8'h00; ex_wb = 8'h00;
		ex_vwe = 1'b0; ex_iwe = 1'b0; ex_push = 1'b0; ex_pop = 1'b0;
		ex_fault = 1'b0; ex_wait = 1'b0; ex_chg = 1'b0; ex_dtwe = 1'b0; ex_stwe = 1'b0;
		case (nib)
			NIB_SYS: begin
				if (op_q == OP_CLS) ex_chg = 1'b1;
				else if (op_q == OP_RET) begin
					if (lvl_q == '0) ex_fault = 1'b1;
					else ex_pop = 1'b1;
				end
			end
			NIB_JP: ex_pc = nnn;
			NIB_CALL: begin
				if (lvl_q >= LEVEL_W'(STACK_DEPTH)) ex_fault = 1'b1;
				else begin
					ex_push = 1'b1;
					ex_pc = nnn;
				end
			end
			NIB_SEI:  if (vx_q == nn) ex_pc = pc4;
			NIB_SNEI: if (vx_q != nn) ex_pc = pc4;
			NIB_SER:  if (ni == 4'h0 && vx_q == vy_q) ex_pc = pc4;
			NIB_SNER: if (ni == 4'h0 && vx_q != vy_q) ex_pc = pc4;
			NIB_LDI: begin ex_vwe = 1'b1; ex_vd = nn; end
			NIB_ADDI: begin ex_vwe = 1'b1; ex_vd = vx_q + nn; end
			NIB_ALU: begin
				case (ni)
					ALU_MOV: begin ex_vwe = 1'b1; ex_vd = vy_q; end
					ALU_OR:  begin ex_vwe = 1'b1; ex_vd = vx_q | vy_q; end
					ALU_AND: begin ex_vwe = 1'b1; ex_vd = vx_q & vy_q; end
					ALU_XOR: begin ex_vwe = 1'b1; ex_vd = vx_q ^ vy_q; end
					ALU_ADD: begin
						ex_vwe = 1'b1; ex_va = FLAG_REG; ex_vd = {7'b0, sum8[8]};
						ex_wb = sum8[7:0];
					end
					ALU_SUB: begin
						ex_vwe = 1'b1; ex_va = FLAG_REG; ex_vd = {7'b0, vx_q >= vy_q};
						ex_wb = vx_q - vy_q;
					end
					ALU_SHR: begin
						ex_vwe = 1'b1; ex_va = FLAG_REG; ex_vd = {7'b0, vx_q[0]};
						ex_wb = {1'b0, vx_q[7:1]};
					end
					ALU_RSB: begin
						ex_vwe = 1'b1; ex_va = FLAG_REG; ex_vd = {7'b0, vy_q >= vx_q};
						ex_wb = vy_q - vx_q;
					end
					ALU_SHL: begin
						ex_vwe = 1'b1; ex_va = FLAG_REG; ex_vd = {7'b0, vx_q[7]};
						ex_wb = {vx_q[6:0], 1'b0};
					end
					default: ex_vwe = 1'b0;
				endcase
			end
			NIB_LDIX: begin ex_iwe = 1'b1; ex_i = nnn; end
			// Vx holds V0 here: the read address was switched at the Vx register read.
			NIB_JPV0: ex_pc = nnn + {4'b0, vx_q};
			NIB_RND:  begin ex_vwe = 1'b1; ex_vd = itm_q.random_byte & nn; end
			NIB_DRW:  ex_chg = 1'b0;
			NIB_KEY: begin
				if (nn == KEY_DOWN && kdown) ex_pc = pc4;
				else if (nn == KEY_UP && !kdown) ex_pc = pc4;
			end
			NIB_MISC: begin
				case (nn)
					FN_GETDT: begin ex_vwe = 1'b1; ex_vd = dt_q; end
					FN_WAITK: begin
						if (kfound) begin ex_vwe = 1'b1; ex_vd = {4'b0, kidx}; end
						else begin ex_wait = 1'b1; ex_pc = pc_q; end
					end
					FN_SETDT: ex_dtwe = 1'b1;
					FN_SETST: ex_stwe = 1'b1;
					FN_ADDI: begin
						ex_iwe = 1'b1; ex_i = sum_i[ADDR_W-1:0];
						ex_vwe = 1'b1; ex_va = FLAG_REG; ex_vd = {7'b0, sum_i[ADDR_W]};
					end
					FN_FONT: begin
						ex_iwe = 1'b1;
						ex_i = font_q + ADDR_W'({vx_q[3:0], 2'b00}) + ADDR_W'(vx_q[3:0]);
					end
					default: ex_iwe = 1'b0;
				endcase
			end
			default: ex_iwe = 1'b0;
		endcase
	end

	// Memory port steering per command.
	always_comb begin
		mem_we = 1'b0; mem_wa = '0; mem_wd = 8'h00; mem_ra = '0;
		v_we = 1'b0; v_wa = '0; v_wd = 8'h00; v_ra = '0;
		stk_we = 1'b0; stk_wa = lvl_q[STK_AW-1:0]; stk_wd = pc2; stk_ra = lvl_m1[STK_AW-1:0];
		fr_we = 1'b0; fr_wa = cnt_q[ROW_AW-1:0]; fr_wd = '0; fr_ra = itm_q.pixel_y;
		case (cmd.code)
			CMD_INIT: begin
				mem_we = 1'b1; mem_wa = cnt_q;
				fr_we = 1'b1;
			end
			CMD_FONT: begin
				mem_we = 1'b1; mem_wa = font_q + cnt_q; mem_wd = glyph_byte(cnt_q[6:0]);
			end
			CMD_MEMWR: begin
				mem_we = 1'b1; mem_wa = itm_q.mem_address; mem_wd = itm_q.mem_byte;
			end
			CMD_FHI: mem_ra = pc_q;
			CMD_FLO: mem_ra = pc1;
			CMD_RX:  v_ra = (hi_q[7:4] == NIB_JPV0) ? 4'h0 : hi_q[3:0];
			CMD_RY:  v_ra = yi;
			CMD_EXEC: begin
				v_we = ex_vwe; v_wa = ex_va; v_wd = ex_vd;
				stk_we = ex_push;
			end
			CMD_WB:  begin v_we = 1'b1; v_wa = xi; v_wd = wb_q; end
			CMD_CLS: fr_we = 1'b1;
			CMD_BCD: begin mem_we = 1'b1; mem_wa = i_q + cnt_q; mem_wd = bcd_byte; end
			CMD_STRD: v_ra = cnt_q[3:0];
			CMD_STWR: begin mem_we = 1'b1; mem_wa = i_q + cnt_q; mem_wd = vrd; end
			CMD_LDRD: mem_ra = i_q + cnt_q;
			CMD_LDWR: begin v_we = 1'b1; v_wa = cnt_q[3:0]; v_wd = mem_rd; end
			CMD_DRD: begin mem_ra = i_q + cnt_q; fr_ra = py_s[ROW_AW-1:0]; end
			CMD_DWR: begin fr_we = row_ok_q; fr_wa = row_q; fr_wd = fr_rd ^ smask; end
			CMD_DVF: begin v_we = 1'b1; v_wa = FLAG_REG; v_wd = {7'b0, hit_q}; end
			default: mem_we = 1'b0;
		endcase
	end

	logic loop_step;
	assign loop_step = (cmd.code == CMD_INIT) || (cmd.code == CMD_FONT) ||
		(cmd.code == CMD_CLS) || (cmd.code == CMD_BCD) || (cmd.code == CMD_STWR) ||
		(cmd.code == CMD_LDWR) || (cmd.code == CMD_DWR);

	logic out_free, fin_load;
	assign out_free = !ovalid_q || result.ready;
	assign fin_load = (cmd.code == CMD_FINISH) && out_free;

	// Control state: counters, machine registers and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_q <= FONT_RESET; pc_q <= START_RESET;
			i_q <= '0; cnt_q <= '0; lvl_q <= '0; dt_q <= 8'h00; st_q <= 8'h00;
			vvalid_q <= '0; ovalid_q <= 1'b0;
		end else begin
			if (cfg_write && cfg_index == CFG_START_ADDRESS) pc_q <= cfg_data;
			if (cfg_write && cfg_index == CFG_FONT_BASE) font_q <= cfg_data;

			if (loop_step) cnt_q <= cnt_q + ADDR_W'(1);
			else if (cmd.code == CMD_NONE || cmd.code == CMD_EXEC) cnt_q <= '0;

			if (v_we) vvalid_q[v_wa] <= 1'b1;

			if (cmd.code == CMD_TICK) begin
				if (dt_q != 8'h00) dt_q <= dt_q - 8'd1;
				if (st_q != 8'h00) st_q <= st_q - 8'd1;
			end
			if (cmd.code == CMD_EXEC) begin
				if (!ex_pop) pc_q <= ex_pc;
				if (ex_iwe) i_q <= ex_i;
				if (ex_push) lvl_q <= lvl_q + LEVEL_W'(1);
				if (ex_pop) lvl_q <= lvl_m1;
				if (ex_dtwe) dt_q <= vx_q;
				if (ex_stwe) st_q <= vx_q;
			end
			if (cmd.code == CMD_RET) pc_q <= stk_rd;

			if (ovalid_q && result.ready) ovalid_q <= 1'b0;
			if (fin_load) ovalid_q <= 1'b1;
		end
	end

	// Item, instruction and result payload.
	always_ff @(posedge clk) begin
		vval_rd_q <= vvalid_q[v_ra];
		if (cmd.take) begin
			itm_q <= itm;
			word_q <= 16'h0000; pix_q <= 1'b0; chg_q <= 1'b0;
			wait_q <= 1'b0; fault_q <= 1'b0;
		end
		case (cmd.code)
			CMD_FLO:    hi_q <= mem_rd;
			CMD_RX: begin
				op_q <= {hi_q, mem_rd};
				word_q <= {hi_q, mem_rd};
			end
			CMD_RY:     vx_q <= vrd;
			CMD_DEC:    vy_q <= vrd;
			CMD_PIXCAP: pix_q <= fr_rd[itm_q.pixel_x];
			CMD_EXEC: begin
				wb_q <= ex_wb;
				chg_q <= ex_chg;
				wait_q <= ex_wait;
				fault_q <= ex_fault;
				hit_q <= 1'b0;
				flip_q <= 1'b0;
			end
			CMD_DRD: begin
				row_ok_q <= py_ok;
				row_q <= py_s[ROW_AW-1:0];
			end
			CMD_DWR: begin
				if (row_ok_q) begin
					if ((fr_rd & smask) != '0) hit_q <= 1'b1;
					if (smask != '0) flip_q <= 1'b1;
				end
			end
			CMD_DVF: chg_q <= flip_q;
			default: hi_q <= hi_q;
		endcase
		if (fin_load) begin
			opc_q <= pc_q; oword_q <= word_q; opix_q <= pix_q; ochg_q <= chg_q;
			owait_q <= wait_q; osnd_q <= (st_q != 8'h00); ofault_q <= fault_q;
		end
	end

	assign result.valid           = ovalid_q;
	assign result.program_counter = opc_q;
	assign result.executed_opcode = oword_q;
	assign result.pixel_value     = opix_q;
	assign result.screen_changed  = ochg_q;
	assign result.key_wait        = owait_q;
	assign result.sound_on        = osnd_q;
	assign result.stack_fault     = ofault_q;

	assign sts.opcode   = op_q;
	assign sts.cnt      = cnt_q;
	assign sts.ret_ok   = (lvl_q != '0);
	assign sts.out_free = out_free;

	// The stack level never passes the stack depth.
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q <= LEVEL_W'(STACK_DEPTH))
		else $error("stack level beyond depth");
	// The result write-back follows the flag write of the same instruction.
	a_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.code == CMD_WB) |-> $past(cmd.code == CMD_EXEC))
		else $error("register write-back without execute");
	// A finished result is loaded only into a free output register.
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		fin_load |=> ovalid_q)
		else $error("result lost at output register");
endmodule

// ----- hdl/chip8_instruction_core.sv -----
// CHIP-8 instruction core, top level: sequencer plus datapath.
// Depends on c8ic_pkg, c8ic_if, c8ic_ctrl and c8ic_dp.
//
// One transaction on item performs one action and returns one transaction on
// result. A memory write or timer tick has its own step and a finish step, a
// pixel read a frame read and a capture, and an ordinary instruction a fetch
// of two bytes, two register reads (through the single read ports of the
// program memory and register file), decode and execute; the flag-setting
// 8XYN forms and a 00EE that returns add a second register or stack step.
// DXYN reads and writes one frame row for each of its N rows, then sets VF;
// FX55 and FX65 read and write V0 to VX, FX33 writes three digits and 00E0
// clears the frame row by row. After reset the core accepts nothing while it
// clears the program memory and loads the font; a write of font_base while
// idle reloads the font. A new item is taken while a finished result still waits.
`timescale 1ns / 1ps
module chip8_instruction_core (
	input  logic                            clk,
	input  logic                            arst_n,
	c8ic_in_if.sink                         item,
	c8ic_out_if.source                      result,
	input  logic                            cfg_write,
	input  logic [c8ic_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [c8ic_pkg::CFG_DATA_W-1:0] cfg_data
);
	import c8ic_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;
	item_t    itm;
	logic     ready;

	// Input payload gathered for the datapath.
	assign itm.action       = item.action;
	assign itm.mem_address  = item.mem_address;
	assign itm.mem_byte     = item.mem_byte;
	assign itm.pressed_keys = item.pressed_keys;
	assign itm.random_byte  = item.random_byte;
	assign itm.pixel_x      = item.pixel_x;
	assign itm.pixel_y      = item.pixel_y;
	assign item.ready       = ready;

	c8ic_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(item.valid), .in_action(item.action),
		.in_ready(ready), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.sts(sts), .cmd(cmd)
	);

	c8ic_dp u_dp (
		.clk(clk), .arst_n(arst_n), .itm(itm), .cfg_write(cfg_write),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .sts(sts),
		.result(result)
	);
endmodule
